[hw/rtl/ets_pkg.sv]
// ets_pkg: shared widths, reciprocal constants, calendar tables and result structs
// for the epoch seconds to calendar pipeline; used by every ets_* module and the top level
package ets_pkg;

    localparam int SECONDS_W   = 32;
    localparam int OUT_TDATA_W = 48;
    localparam int DAYS_W      = 16;
    localparam int SOD_W       = 17;
    localparam int YIDX_W      = 8;
    localparam int YDAY_W      = 9;
    localparam int PIPE_DEPTH  = 7;

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
    localparam logic [2:0]  DAYS_PER_WEEK = 3'd7;

    // floor(2^32 / 675): days = (t >> 7) / 675, estimate is exact or one low
    localparam logic [22:0] DAY_RECIP     = 23'd6362914;
    // ceil(2^20 / 225): hour = (sod >> 4) / 225, exact for sod < 86400
    localparam logic [12:0] HOUR_RECIP    = 13'd4661;
    // ceil(2^14 / 15): minute = (secs >> 2) / 15, exact for secs < 3600
    localparam logic [10:0] MIN_RECIP     = 11'd1093;
    // ceil(2^19 / 7): exact for the whole day range
    localparam logic [16:0] WDAY_RECIP    = 17'd74899;
    // floor(2^24 / 366): year index estimate, never high, at most one low
    localparam logic [15:0] YEAR_RECIP    = 16'd45839;

    localparam logic [2:0]  EPOCH_WEEKDAY   = 3'd4;
    localparam logic [7:0]  CAL_YEAR_OFS    = 8'd70;
    localparam logic [7:0]  NO_LEAP_CENTURY = 8'd200;

    localparam int FIRST_YEAR   = 1970;
    localparam int NO_LEAP_YEAR = 2100;
    localparam int YEAR_COUNT   = 138;

    typedef logic [DAYS_W-1:0] t_year_table [YEAR_COUNT];
    typedef logic [YDAY_W-1:0] t_month_table [12];

    // days from the epoch to 1 january of each year 1970 .. 2107
    function automatic t_year_table build_year_table();
        t_year_table tbl;
        int          acc;
        int          yr;
        acc = 0;
        for (int n = 0; n < YEAR_COUNT; n++) begin
            tbl[n] = DAYS_W'(acc);
            yr     = FIRST_YEAR + n;
            acc    = acc + ((((yr & 3) == 0) && (yr != NO_LEAP_YEAR)) ? 366 : 365);
        end
        return tbl;
    endfunction

    localparam t_year_table YEAR_START = build_year_table();

    localparam t_month_table MONTH_START = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    // first day of year of a month, one later from march on in a leap year
    function automatic logic [YDAY_W-1:0] month_start(input logic [3:0] m, input logic leap);
        logic [YDAY_W-1:0] base;
        base = (m < 4'd12) ? MONTH_START[m] : MONTH_START[0];
        return base + YDAY_W'(leap && (m >= 4'd2));
    endfunction

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_clock;

    typedef struct packed {
        logic [2:0] weekday;
        logic [8:0] day_of_year;
        logic [7:0] years_since_1900;
        logic [3:0] month_index;
        logic [4:0] day_of_month;
    } t_date;

endpackage

[hw/rtl/epoch_seconds_to_calendar.sv]
// epoch_seconds_to_calendar: top level, stream ports, valid pipeline and result packing
// depends on ets_pkg, ets_day_split, ets_clock, ets_date
//
// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 UTC into
// the Gregorian UTC calendar breakdown, one result word per input word.
// Input stream: i_s_tdata carries the seconds; a word is taken when i_s_tvalid
// and o_s_tready are both high. Output stream: o_m_tdata carries the eight
// calendar fields; a word leaves when o_m_tvalid and i_m_tready are both high.
// Seven register stages lie between the accepting edge and o_m_tvalid; a word can
// leave once it reaches the last stage. Three stages split
// seconds into days and seconds of day, four more derive time of day and date
// from parallel reciprocal multipliers and constant year and month tables.
// Throughput is one word per cycle while the receiver does not stall; every stage holds one word.
// When the receiver stalls with a word waiting at the output, the whole pipeline
// holds and o_s_tready drops in the same cycle; nothing is lost or repeated.
// Reset clears only the stage valid bits; the block keeps no other state.
module epoch_seconds_to_calendar (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // [31:0] unix_seconds
    input  logic [ets_pkg::SECONDS_W-1:0]   i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [5:0] second, [11:6] minute, [16:12] hour, [21:17] day_of_month,
    // [25:22] month_index, [33:26] years_since_1900, [42:34] day_of_year,
    // [45:43] weekday, [47:46] zero
    output logic [ets_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int LAST = ets_pkg::PIPE_DEPTH - 1;

    logic [ets_pkg::PIPE_DEPTH-1:0] r_vld;
    logic                           w_en;
    logic [ets_pkg::DAYS_W-1:0]     w_days;
    logic [ets_pkg::SOD_W-1:0]      w_sod;
    ets_pkg::t_clock                w_clock;
    ets_pkg::t_date                 w_date;

    // advance unless the output word is held by the receiver
    assign w_en       = !r_vld[LAST] || i_m_tready;
    assign o_s_tready = w_en;
    assign o_m_tvalid = r_vld[LAST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAST-1:0], i_s_tvalid};
        end
    end

    ets_day_split u_day_split (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_seconds (i_s_tdata),
        .o_days    (w_days),
        .o_sod     (w_sod)
    );

    ets_clock u_clock (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_sod   (w_sod),
        .o_clock (w_clock)
    );

    ets_date u_date (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_days (w_days),
        .o_date (w_date)
    );

    assign o_m_tdata = {2'b00, w_date.weekday, w_date.day_of_year,
                        w_date.years_since_1900, w_date.month_index,
                        w_date.day_of_month, w_clock.hour, w_clock.minute,
                        w_clock.second};

    a_clock_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (w_clock.hour < 5'd24 && w_clock.minute < 6'd60
                        && w_clock.second < 6'd60))
        else $error("time of day out of range");

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (w_date.day_of_month != 5'd0 && w_date.month_index < 4'd12
                        && w_date.weekday < 3'd7))
        else $error("date field out of range");

    a_january: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && w_date.month_index == 4'd0)
            |-> (w_date.day_of_year == 9'(w_date.day_of_month) - 9'd1))
        else $error("day of year disagrees with day of month in january");

    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_vld[0])
        else $error("accepted word not marked valid in first stage");

endmodule

[hw/rtl/ets_day_split.sv]
// ets_day_split: stages 1 to 3, splits epoch seconds into whole days and seconds of day
// depends on ets_pkg
module ets_day_split (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [ets_pkg::SECONDS_W-1:0] i_seconds,
    output logic [ets_pkg::DAYS_W-1:0]    o_days,
    output logic [ets_pkg::SOD_W-1:0]     o_sod
);

    logic [ets_pkg::SECONDS_W-1:0] r_s1_t;
    logic [ets_pkg::DAYS_W-1:0]    r_s1_q;
    logic [ets_pkg::SECONDS_W-1:0] r_s2_t;
    logic [ets_pkg::DAYS_W-1:0]    r_s2_q;
    logic [ets_pkg::SECONDS_W-1:0] r_s2_prod;
    logic [ets_pkg::DAYS_W-1:0]    r_s3_days;
    logic [ets_pkg::SOD_W-1:0]     r_s3_sod;

    logic [47:0]                   n_s1_prod;
    logic [ets_pkg::DAYS_W-1:0]    n_s1_q;
    logic [32:0]                   n_s2_full;
    logic [ets_pkg::SECONDS_W-1:0] n_s2_prod;
    logic [ets_pkg::SECONDS_W-1:0] n_s3_diff_w;
    logic [17:0]                   n_s3_diff;
    logic [ets_pkg::DAYS_W-1:0]    n_s3_days;
    logic [ets_pkg::SOD_W-1:0]     n_s3_sod;

    always_comb begin
        // 86400 = 675 * 128, so divide the upper 25 bits by 675
        n_s1_prod = 48'(i_seconds[31:7]) * 48'(ets_pkg::DAY_RECIP);
        n_s1_q    = n_s1_prod[47:32];

        n_s2_full = 33'(r_s1_q) * 33'(ets_pkg::SECS_PER_DAY);
        n_s2_prod = n_s2_full[31:0];

        // remainder below twice a day: one correction step
        n_s3_diff_w = r_s2_t - r_s2_prod;
        n_s3_diff   = n_s3_diff_w[17:0];
        if (n_s3_diff >= 18'(ets_pkg::SECS_PER_DAY)) begin
            n_s3_days = r_s2_q + 16'd1;
            n_s3_sod  = 17'(n_s3_diff - 18'(ets_pkg::SECS_PER_DAY));
        end else begin
            n_s3_days = r_s2_q;
            n_s3_sod  = n_s3_diff[16:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_t    <= i_seconds;
            r_s1_q    <= n_s1_q;
            r_s2_t    <= r_s1_t;
            r_s2_q    <= r_s1_q;
            r_s2_prod <= n_s2_prod;
            r_s3_days <= n_s3_days;
            r_s3_sod  <= n_s3_sod;
        end
    end

    assign o_days = r_s3_days;
    assign o_sod  = r_s3_sod;

endmodule

[hw/rtl/ets_clock.sv]
// ets_clock: stages 4 to 7, hour, minute and second from the seconds of day
// depends on ets_pkg
module ets_clock (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [ets_pkg::SOD_W-1:0] i_sod,
    output ets_pkg::t_clock           o_clock
);

    logic [ets_pkg::SOD_W-1:0] r_s4_sod;
    logic [4:0]                r_s4_hour;
    logic [4:0]                r_s5_hour;
    logic [11:0]               r_s5_ms;
    logic [4:0]                r_s6_hour;
    logic [11:0]               r_s6_ms;
    logic [5:0]                r_s6_minute;
    ets_pkg::t_clock           r_s7_clock;

    logic [25:0]               n_s4_prod;
    logic [16:0]               n_s5_hsecs;
    logic [16:0]               n_s5_diff;
    logic [20:0]               n_s6_prod;
    logic [11:0]               n_s7_msecs;
    logic [11:0]               n_s7_diff;

    always_comb begin
        n_s4_prod  = 26'(i_sod[16:4]) * 26'(ets_pkg::HOUR_RECIP);
        n_s5_hsecs = 17'(r_s4_hour) * 17'(ets_pkg::SECS_PER_HOUR);
        n_s5_diff  = r_s4_sod - n_s5_hsecs;
        n_s6_prod  = 21'(r_s5_ms[11:2]) * 21'(ets_pkg::MIN_RECIP);
        n_s7_msecs = 12'(r_s6_minute) * 12'(ets_pkg::SECS_PER_MIN);
        n_s7_diff  = r_s6_ms - n_s7_msecs;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s4_sod           <= i_sod;
            r_s4_hour          <= n_s4_prod[24:20];
            r_s5_hour          <= r_s4_hour;
            r_s5_ms            <= n_s5_diff[11:0];
            r_s6_hour          <= r_s5_hour;
            r_s6_ms            <= r_s5_ms;
            r_s6_minute        <= n_s6_prod[19:14];
            r_s7_clock.hour    <= r_s6_hour;
            r_s7_clock.minute  <= r_s6_minute;
            r_s7_clock.second  <= n_s7_diff[5:0];
        end
    end

    assign o_clock = r_s7_clock;

endmodule

[hw/rtl/ets_date.sv]
// ets_date: stages 4 to 7, weekday, year, day of year, month and day from the day count
// depends on ets_pkg (year start and month start tables)
module ets_date (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [ets_pkg::DAYS_W-1:0] i_days,
    output ets_pkg::t_date             o_date
);

    logic [ets_pkg::DAYS_W-1:0] r_s4_days;
    logic [ets_pkg::YIDX_W-1:0] r_s4_est;
    logic [ets_pkg::DAYS_W-1:0] r_s4_w;
    logic [12:0]                r_s4_q7;
    logic [7:0]                 r_s5_years;
    logic [ets_pkg::YDAY_W-1:0] r_s5_yday;
    logic [2:0]                 r_s5_wday;
    logic [7:0]                 r_s6_years;
    logic [ets_pkg::YDAY_W-1:0] r_s6_yday;
    logic [2:0]                 r_s6_wday;
    logic [3:0]                 r_s6_month;
    logic                       r_s6_leap;
    ets_pkg::t_date             r_s7_date;

    logic [31:0]                n_s4_yprod;
    logic [ets_pkg::DAYS_W-1:0] n_s4_w;
    logic [31:0]                n_s4_wprod;
    logic [ets_pkg::YIDX_W-1:0] n_s5_next;
    logic [ets_pkg::DAYS_W-1:0] n_s5_lo;
    logic [ets_pkg::DAYS_W-1:0] n_s5_hi;
    logic [ets_pkg::YIDX_W-1:0] n_s5_idx;
    logic [ets_pkg::DAYS_W-1:0] n_s5_yday;
    logic [ets_pkg::DAYS_W-1:0] n_s5_w7;
    logic [ets_pkg::DAYS_W-1:0] n_s5_wday;
    logic                       n_s6_leap;
    logic [3:0]                 n_s6_month;
    logic [ets_pkg::YDAY_W-1:0] n_s7_day;

    always_comb begin
        n_s4_yprod = 32'(i_days) * 32'(ets_pkg::YEAR_RECIP);
        n_s4_w     = i_days + 16'(ets_pkg::EPOCH_WEEKDAY);
        n_s4_wprod = 32'(n_s4_w) * 32'(ets_pkg::WDAY_RECIP);

        // the estimate is the year or the one before it
        n_s5_next = r_s4_est + 8'd1;
        n_s5_lo   = ets_pkg::YEAR_START[r_s4_est];
        n_s5_hi   = ets_pkg::YEAR_START[n_s5_next];
        if (r_s4_days >= n_s5_hi) begin
            n_s5_idx  = n_s5_next;
            n_s5_yday = r_s4_days - n_s5_hi;
        end else begin
            n_s5_idx  = r_s4_est;
            n_s5_yday = r_s4_days - n_s5_lo;
        end
        n_s5_w7   = 16'(r_s4_q7) * 16'(ets_pkg::DAYS_PER_WEEK);
        n_s5_wday = r_s4_w - n_s5_w7;

        // 1900 + y is divisible by 4 exactly when y is; 2100 is the only skipped century
        n_s6_leap  = (r_s5_years[1:0] == 2'd0) && (r_s5_years != ets_pkg::NO_LEAP_CENTURY);
        n_s6_month = 4'd0;
        for (int m = 1; m < 12; m++) begin
            n_s6_month = n_s6_month
                       + 4'(r_s5_yday >= ets_pkg::month_start(4'(m), n_s6_leap));
        end

        n_s7_day = r_s6_yday - ets_pkg::month_start(r_s6_month, r_s6_leap) + 9'd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s4_days  <= i_days;
            r_s4_est   <= n_s4_yprod[31:24];
            r_s4_w     <= n_s4_w;
            r_s4_q7    <= n_s4_wprod[31:19];
            r_s5_years <= ets_pkg::CAL_YEAR_OFS + n_s5_idx;
            r_s5_yday  <= n_s5_yday[ets_pkg::YDAY_W-1:0];
            r_s5_wday  <= n_s5_wday[2:0];
            r_s6_years <= r_s5_years;
            r_s6_yday  <= r_s5_yday;
            r_s6_wday  <= r_s5_wday;
            r_s6_month <= n_s6_month;
            r_s6_leap  <= n_s6_leap;
            r_s7_date.weekday          <= r_s6_wday;
            r_s7_date.day_of_year      <= r_s6_yday;
            r_s7_date.years_since_1900 <= r_s6_years;
            r_s7_date.month_index      <= r_s6_month;
            r_s7_date.day_of_month     <= n_s7_day[4:0];
        end
    end

    assign o_date = r_s7_date;

endmodule
